@@ hdl/pcp_pkg.sv @@
package pcp_pkg;

  // default build values
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // fixed widths of the arithmetic
  localparam int RECIP_W    = 57;  // floor(2^56 / xw), xw >= 1
  localparam int MAG_W      = 32;  // clamped magnitude, at most 2^31
  localparam int E_W        = 31;  // exp argument, at most 2^30
  localparam int G_W        = 33;  // exp result, Q0.32 up to 1.0
  localparam int FIFO_DEPTH = 4;

  // constants of the fixed-point scheme
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [63:0] LN2_Q32    = 64'd2977044472;
  localparam logic [63:0] E_CAP      = 64'd1 << 30;
  localparam logic [63:0] MAG_CAP    = 64'd1 << 31;
  localparam logic [63:0] M_CAP      = 64'd1 << 62;
  localparam int          ROUND_HALF = 16384;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIR_COS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 3'd6;

  typedef logic [1:0] zone_t;

  localparam zone_t ZONE_COMPUTED = 2'd0;
  localparam zone_t ZONE_BELOW    = 2'd1;
  localparam zone_t ZONE_UPWIND   = 2'd2;

  // wind direction, Q1.15 each
  typedef struct packed {
    logic [15:0] cos_q15;
    logic [15:0] sin_q15;
  } dir_t;

  // coefficients used by the evaluation pipeline
  typedef struct packed {
    logic [31:0] spread;
    logic [31:0] amplitude;
    logic [23:0] decay;
  } coef_t;

  // magnitude of a signed value, clamped to 2^31
  function automatic logic [MAG_W-1:0] clamp_mag(logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return (m > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : m[MAG_W-1:0];
  endfunction

  // exp(-y) by a 21-term series, y in Q0.32, result Q0.32
  function automatic logic [G_W-1:0] exp_entry(logic [63:0] y);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 20; k++) begin
      prod = term * y;
      term = (prod >> 32) / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[G_W-1:0];
  endfunction

endpackage

@@ hdl/pcp_in_if.sv @@
interface pcp_in_if #(
  parameter int COORD_WIDTH = pcp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] east_offset;
  logic signed [COORD_WIDTH-1:0] north_offset;
  logic signed [COORD_WIDTH-1:0] point_height;
  logic signed [COORD_WIDTH-1:0] terrain_height;

  modport source (
    output valid, east_offset, north_offset, point_height, terrain_height,
    input  ready
  );
  modport sink (
    input  valid, east_offset, north_offset, point_height, terrain_height,
    output ready
  );
endinterface

@@ hdl/pcp_out_if.sv @@
interface pcp_out_if;
  logic                valid;
  logic                ready;
  logic [31:0]         concentration;
  pcp_pkg::zone_t      zone;

  modport source (
    output valid, concentration, zone,
    input  ready
  );
  modport sink (
    input  valid, concentration, zone,
    output ready
  );
endinterface

@@ hdl/pcp_fifo.sv @@
module pcp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = pcp_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/pcp_front.sv @@
module pcp_front #(
  parameter int COORD_WIDTH = pcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pcp_in_if.sink                        in_if,
  input  pcp_pkg::dir_t                 dir,
  input  logic signed [COORD_WIDTH-1:0] source_height,
  input  logic signed [COORD_WIDTH-1:0] mirror_height,
  input  logic                          fifo_full,
  output logic                          push,
  output logic [2+COORD_WIDTH+1+3*pcp_pkg::MAG_W-1:0] entry
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 16;
  localparam int SW = CW + 17;
  localparam int XW = CW + 2;
  localparam int DW = CW + 1;
  localparam int MW = pcp_pkg::MAG_W;

  logic                 en_f;
  logic                 accept;
  logic                 a_vld_r;
  logic                 b_vld_r;

  logic signed [PW-1:0] pcx_r;
  logic signed [PW-1:0] psy_r;
  logic signed [PW-1:0] pcy_r;
  logic signed [PW-1:0] psx_r;
  logic                 below_r;
  logic signed [DW-1:0] zd_r;
  logic signed [DW-1:0] zm_r;

  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [XW-1:0] xw_s;
  logic signed [XW-1:0] yw_s;
  pcp_pkg::zone_t       zone_nxt;

  pcp_pkg::zone_t       zone_r;
  logic [CW:0]          xw_r;
  logic [MW-1:0]        ywm_r;
  logic [MW-1:0]        zdm_r;
  logic [MW-1:0]        zmm_r;

  // the front moves whenever its last stage can hand off
  assign en_f        = !b_vld_r || !fifo_full;
  assign in_if.ready = en_f;
  assign accept      = in_if.valid && en_f;
  assign push        = b_vld_r && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en_f) begin
      a_vld_r <= accept;
      b_vld_r <= a_vld_r;
    end
  end

  // stage a: rotation products, terrain test, heights above both sources
  always_ff @(posedge clk) begin
    if (en_f) begin
      pcx_r   <= $signed(in_if.east_offset)  * $signed(dir.cos_q15);
      psy_r   <= $signed(in_if.north_offset) * $signed(dir.sin_q15);
      pcy_r   <= $signed(in_if.north_offset) * $signed(dir.cos_q15);
      psx_r   <= $signed(in_if.east_offset)  * $signed(dir.sin_q15);
      below_r <= in_if.point_height < in_if.terrain_height;
      zd_r    <= DW'(in_if.point_height) - DW'(source_height);
      zm_r    <= DW'(in_if.point_height) - DW'(mirror_height);
    end
  end

  // stage b: rounded downwind / crosswind distances and classification
  always_comb begin
    sx   = SW'(pcx_r) + SW'(psy_r) + SW'(pcp_pkg::ROUND_HALF);
    sy   = SW'(pcy_r) - SW'(psx_r) + SW'(pcp_pkg::ROUND_HALF);
    xw_s = XW'(sx >>> 15);
    yw_s = XW'(sy >>> 15);
    if (below_r) begin
      zone_nxt = pcp_pkg::ZONE_BELOW;
    end else if (xw_s[XW-1] || (xw_s == '0)) begin
      zone_nxt = pcp_pkg::ZONE_UPWIND;
    end else begin
      zone_nxt = pcp_pkg::ZONE_COMPUTED;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      zone_r <= zone_nxt;
      xw_r   <= xw_s[CW:0];
      ywm_r  <= pcp_pkg::clamp_mag(64'(yw_s));
      zdm_r  <= pcp_pkg::clamp_mag(64'(zd_r));
      zmm_r  <= pcp_pkg::clamp_mag(64'(zm_r));
    end
  end

  assign entry = {zone_r, xw_r, ywm_r, zdm_r, zmm_r};

endmodule

@@ hdl/pcp_recip.sv @@
module pcp_recip #(
  parameter int XU = pcp_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [XU-1:0]               dv,
  output logic [pcp_pkg::RECIP_W-1:0] quo
);

  // restoring division of 2^56 by dv, one quotient bit per stage
  localparam int RW = pcp_pkg::RECIP_W;

  logic [XU-1:0] rem_r [RW];
  logic [RW-1:0] quo_r [RW];
  logic [XU-1:0] dv_r  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [XU-1:0] rem_in;
    logic [RW-1:0] quo_in;
    logic [XU-1:0] dv_in;
    logic [XU:0]   trial;
    logic          qbit;
    logic [XU:0]   diff;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dv_in  = dv;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign dv_in  = dv_r[j-1];
    end

    // the only set dividend bit is the first one brought down
    assign trial = {rem_in, (j == 0) ? 1'b1 : 1'b0};
    assign diff  = trial - {1'b0, dv_in};
    assign qbit  = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= qbit ? diff[XU-1:0] : trial[XU-1:0];
        quo_r[j] <= {quo_in[RW-2:0], qbit};
        dv_r[j]  <= dv_in;
      end
    end
  end

  assign quo = quo_r[RW-1];

endmodule

@@ hdl/pcp_exp.sv @@
module pcp_exp #(
  parameter int EXP_TABLE_DEPTH = pcp_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [pcp_pkg::E_W-1:0] e_in,
  output logic [pcp_pkg::G_W-1:0] g_out
);

  // exp(-e) as 2^-(e*log2e): table of 2^(-i/depth), linear interpolation,
  // then a right shift by the integer part; five stages
  localparam int GW  = pcp_pkg::G_W;
  localparam int IXW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PRW = pcp_pkg::E_W + 17;

  logic [GW-1:0]  rom [EXP_TABLE_DEPTH+1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] YK = (pcp_pkg::LN2_Q32 * 64'(k)) / EXP_TABLE_DEPTH;
    assign rom[k] = pcp_pkg::exp_entry(YK);
  end

  logic [PRW-1:0] pr_r;
  logic [15:0]    n_w;
  logic [31:0]    p_w;
  logic [IXW-1:0] idx_r;
  logic [15:0]    frac2_r;
  logic [5:0]     sh2_r;
  logic           zero2_r;
  logic [GW-1:0]  t0_r;
  logic [GW-1:0]  diff_r;
  logic [15:0]    frac3_r;
  logic [5:0]     sh3_r;
  logic           zero3_r;
  logic [GW+15:0] dm_r;
  logic [GW-1:0]  t0b_r;
  logic [5:0]     sh4_r;
  logic           zero4_r;
  logic [GW-1:0]  v_w;
  logic [GW-1:0]  g_r;

  // stage 1: scale to base two
  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= PRW'(e_in) * PRW'(pcp_pkg::LOG2E_Q16);
    end
  end

  // stage 2: integer shift, table index and fraction
  assign n_w = pr_r[47:32];
  assign p_w = 32'(pr_r[31:16]) * 32'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      zero2_r <= (n_w > 16'd63);
      sh2_r   <= n_w[5:0];
      idx_r   <= p_w[16 +: IXW];
      frac2_r <= p_w[15:0];
    end
  end

  // stage 3: table lookup at both neighbors
  always_ff @(posedge clk) begin
    if (en) begin
      t0_r    <= rom[idx_r];
      diff_r  <= rom[idx_r] - rom[idx_r + IXW'(1)];
      frac3_r <= frac2_r;
      sh3_r   <= sh2_r;
      zero3_r <= zero2_r;
    end
  end

  // stage 4: interpolation product
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r    <= (GW+16)'(diff_r) * (GW+16)'(frac3_r);
      t0b_r   <= t0_r;
      sh4_r   <= sh3_r;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: interpolated value, shifted down
  assign v_w = t0b_r - dm_r[GW+15:16];

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= zero4_r ? '0 : (v_w >> sh4_r);
    end
  end

  assign g_out = g_r;

endmodule

@@ hdl/pcp_back.sv @@
module pcp_back #(
  parameter int COORD_WIDTH     = pcp_pkg::COORD_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = pcp_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcp_pkg::coef_t       coef,
  input  logic                 fifo_empty,
  input  logic [2+COORD_WIDTH+1+3*pcp_pkg::MAG_W-1:0] entry,
  output logic                 pop,
  pcp_out_if.source            out_if
);

  localparam int XU = COORD_WIDTH + 1;
  localparam int MW = pcp_pkg::MAG_W;
  localparam int RW = pcp_pkg::RECIP_W;
  localparam int EW = pcp_pkg::E_W;
  localparam int GW = pcp_pkg::G_W;
  localparam int SR = RW;          // stage at which the reciprocal is ready
  localparam int NS = SR + 15;     // output stage
  localparam int DPW = 24 + XU;    // decay product width
  localparam int RD  = 11;         // reciprocal hold until last use

  logic           en;
  logic           vld_r [NS+1];

  pcp_pkg::zone_t zone_h;
  logic [XU-1:0]  xw_h;
  logic [MW-1:0]  yw_h;
  logic [MW-1:0]  zd_h;
  logic [MW-1:0]  zm_h;

  pcp_pkg::zone_t zone_s0_r;
  logic [XU-1:0]  xw_s0_r;
  logic [MW-1:0]  yw_s0_r;
  logic [MW-1:0]  zd_s0_r;
  logic [MW-1:0]  zm_s0_r;

  logic [RW-1:0]  recip;

  logic [MW-1:0]  yw_dl_r [SR-2];
  logic [MW-1:0]  zd_dl_r [SR-2];
  logic [MW-1:0]  zm_dl_r [SR-2];
  logic [XU-1:0]  xw_dl_r [SR+3];
  logic [RW-1:0]  r_dl_r  [RD];
  pcp_pkg::zone_t z_dl_r  [SR+14];

  logic [63:0]    yq_r;
  logic [63:0]    zdq_r;
  logic [63:0]    zmq_r;
  logic [63:0]    q1_r;
  logic [63:0]    q2_r;

  logic [63:0]    pa00_r, pa10_r, pb00_r, pb10_r;
  logic [56:0]    pa01_r, pa11_r, pb01_r, pb11_r;
  logic [120:0]   fa_w, fb_w;
  logic [62:0]    m1_r, m2_r;

  logic [63:0]    sa0_r, sb0_r;
  logic [62:0]    sa1_r, sb1_r;
  logic [94:0]    fsa_w, fsb_w;
  logic [EW-1:0]  e1_r, e2_r;

  logic [DPW-1:0] dprod_r;
  logic [DPW-17:0] dsh_w;
  logic [EW-1:0]  darg_r;

  logic [GW-1:0]  g1, g2, dec;
  logic [GW:0]    gsum_r;
  logic [66:0]    gp_r;
  logic [34:0]    p_w;
  logic [66:0]    pm0_r;
  logic [59:0]    pm1_r;
  logic [91:0]    fm_w;
  logic [43:0]    mm_r;
  logic [63:0]    am0_r;
  logic [43:0]    am1_r;
  logic [75:0]    fo_w;
  logic [43:0]    co_w;

  logic [31:0]    conc_r;
  pcp_pkg::zone_t zone_out_r;

  // the whole evaluation pipeline advances unless the result is held
  assign en  = !vld_r[NS] || out_if.ready;
  assign pop = en && !fifo_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= pop;
      for (int k = 1; k <= NS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0: take the request from the queue
  assign {zone_h, xw_h, yw_h, zd_h, zm_h} = entry;

  always_ff @(posedge clk) begin
    if (en) begin
      zone_s0_r <= zone_h;
      xw_s0_r   <= xw_h;
      yw_s0_r   <= yw_h;
      zd_s0_r   <= zd_h;
      zm_s0_r   <= zm_h;
    end
  end

  // reciprocal of the downwind distance
  pcp_recip #(.XU(XU)) u_recip (
    .clk (clk),
    .en  (en),
    .dv  (xw_s0_r),
    .quo (recip)
  );

  // hold lines alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      yw_dl_r[0] <= yw_s0_r;
      zd_dl_r[0] <= zd_s0_r;
      zm_dl_r[0] <= zm_s0_r;
      for (int k = 1; k < SR - 2; k++) begin
        yw_dl_r[k] <= yw_dl_r[k-1];
        zd_dl_r[k] <= zd_dl_r[k-1];
        zm_dl_r[k] <= zm_dl_r[k-1];
      end
      xw_dl_r[0] <= xw_s0_r;
      for (int k = 1; k < SR + 3; k++) begin
        xw_dl_r[k] <= xw_dl_r[k-1];
      end
      z_dl_r[0] <= zone_s0_r;
      for (int k = 1; k < SR + 14; k++) begin
        z_dl_r[k] <= z_dl_r[k-1];
      end
      r_dl_r[0] <= recip;
      for (int k = 1; k < RD; k++) begin
        r_dl_r[k] <= r_dl_r[k-1];
      end
    end
  end

  // squared distances to the direct and the mirrored source
  always_ff @(posedge clk) begin
    if (en) begin
      yq_r  <= 64'(yw_dl_r[SR-3]) * 64'(yw_dl_r[SR-3]);
      zdq_r <= 64'(zd_dl_r[SR-3]) * 64'(zd_dl_r[SR-3]);
      zmq_r <= 64'(zm_dl_r[SR-3]) * 64'(zm_dl_r[SR-3]);
      q1_r  <= yq_r + zdq_r;
      q2_r  <= yq_r + zmq_r;
    end
  end

  // q * recip, split into 32-bit partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pa00_r <= 64'(q1_r[31:0])  * 64'(recip[31:0]);
      pa01_r <= 57'(q1_r[31:0])  * 57'(recip[56:32]);
      pa10_r <= 64'(q1_r[63:32]) * 64'(recip[31:0]);
      pa11_r <= 57'(q1_r[63:32]) * 57'(recip[56:32]);
      pb00_r <= 64'(q2_r[31:0])  * 64'(recip[31:0]);
      pb01_r <= 57'(q2_r[31:0])  * 57'(recip[56:32]);
      pb10_r <= 64'(q2_r[63:32]) * 64'(recip[31:0]);
      pb11_r <= 57'(q2_r[63:32]) * 57'(recip[56:32]);
    end
  end

  assign fa_w = 121'(pa00_r) + (121'(pa01_r) << 32) + (121'(pa10_r) << 32)
              + (121'(pa11_r) << 64);
  assign fb_w = 121'(pb00_r) + (121'(pb01_r) << 32) + (121'(pb10_r) << 32)
              + (121'(pb11_r) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= (fa_w[120:40] > 81'(pcp_pkg::M_CAP)) ? pcp_pkg::M_CAP[62:0]
                                                   : fa_w[102:40];
      m2_r <= (fb_w[120:40] > 81'(pcp_pkg::M_CAP)) ? pcp_pkg::M_CAP[62:0]
                                                   : fb_w[102:40];
    end
  end

  // spread * m, exponent of each gaussian term
  always_ff @(posedge clk) begin
    if (en) begin
      sa0_r <= 64'(coef.spread) * 64'(m1_r[31:0]);
      sa1_r <= 63'(coef.spread) * 63'(m1_r[62:32]);
      sb0_r <= 64'(coef.spread) * 64'(m2_r[31:0]);
      sb1_r <= 63'(coef.spread) * 63'(m2_r[62:32]);
    end
  end

  assign fsa_w = 95'(sa0_r) + (95'(sa1_r) << 32);
  assign fsb_w = 95'(sb0_r) + (95'(sb1_r) << 32);

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r <= (fsa_w[94:24] > 71'(pcp_pkg::E_CAP)) ? pcp_pkg::E_CAP[EW-1:0]
                                                   : fsa_w[24 +: EW];
      e2_r <= (fsb_w[94:24] > 71'(pcp_pkg::E_CAP)) ? pcp_pkg::E_CAP[EW-1:0]
                                                   : fsb_w[24 +: EW];
    end
  end

  pcp_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_direct (
    .clk   (clk),
    .en    (en),
    .e_in  (e1_r),
    .g_out (g1)
  );

  pcp_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_mirror (
    .clk   (clk),
    .en    (en),
    .e_in  (e2_r),
    .g_out (g2)
  );

  // decay along the downwind distance, one stage behind the gaussians
  assign dsh_w = dprod_r[DPW-1:16];

  always_ff @(posedge clk) begin
    if (en) begin
      dprod_r <= DPW'(coef.decay) * DPW'(xw_dl_r[SR+2]);
      darg_r  <= (64'(dsh_w) > pcp_pkg::E_CAP) ? pcp_pkg::E_CAP[EW-1:0]
                                               : dsh_w[EW-1:0];
    end
  end

  pcp_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_decay (
    .clk   (clk),
    .en    (en),
    .e_in  (darg_r),
    .g_out (dec)
  );

  // (g1 + g2) * decay, then times recip
  assign p_w = gp_r[66:32];

  always_ff @(posedge clk) begin
    if (en) begin
      gsum_r <= (GW+1)'(g1) + (GW+1)'(g2);
      gp_r   <= 67'(gsum_r) * 67'(dec);
      pm0_r  <= 67'(p_w) * 67'(r_dl_r[RD-1][31:0]);
      pm1_r  <= 60'(p_w) * 60'(r_dl_r[RD-1][56:32]);
    end
  end

  assign fm_w = 92'(pm0_r) + (92'(pm1_r) << 32);

  // amplitude scaling
  always_ff @(posedge clk) begin
    if (en) begin
      mm_r  <= fm_w[91:48];
      am0_r <= 64'(coef.amplitude) * 64'(mm_r[31:0]);
      am1_r <= 44'(coef.amplitude) * 44'(mm_r[43:32]);
    end
  end

  assign fo_w = 76'(am0_r) + (76'(am1_r) << 32);
  assign co_w = fo_w[75:32];

  // output register, saturated, forced to zero outside the plume
  always_ff @(posedge clk) begin
    if (en) begin
      zone_out_r <= z_dl_r[SR+13];
      if (z_dl_r[SR+13] != pcp_pkg::ZONE_COMPUTED) begin
        conc_r <= '0;
      end else if (co_w > 44'hFFFF_FFFF) begin
        conc_r <= '1;
      end else begin
        conc_r <= co_w[31:0];
      end
    end
  end

  assign out_if.valid         = vld_r[NS];
  assign out_if.concentration = conc_r;
  assign out_if.zone          = zone_out_r;

endmodule

@@ hdl/plume_concentration_point_top.sv @@
// Gaussian plume concentration at one receptor per request, with ground
// reflection. A front stage rotates the offset into downwind/crosswind
// axes and classifies the point (below terrain, upwind, or computed); a
// four-entry queue feeds the evaluation pipeline, which takes one request
// per cycle unless the result is held, and returns one result per request
// in order. Sustained rate is one request per clock while the result is not
// held. A request passes two front stages, the queue, then the back stages,
// set by the 57-stage reciprocal divider of the downwind distance plus the
// exp units and the split multipliers behind it. Configuration is to be
// written only while idle; the block itself does not enforce this.
module plume_concentration_point_top #(
  parameter int COORD_WIDTH     = pcp_pkg::COORD_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = pcp_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pcp_in_if.sink                           in_if,
  pcp_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int EW = 2 + COORD_WIDTH + 1 + 3 * pcp_pkg::MAG_W;

  pcp_pkg::dir_t                 dir_r;
  logic signed [COORD_WIDTH-1:0] source_height_r;
  logic signed [COORD_WIDTH-1:0] mirror_height_r;
  pcp_pkg::coef_t                coef_r;

  logic          push;
  logic          pop;
  logic          fifo_full;
  logic          fifo_empty;
  logic [EW-1:0] push_entry;
  logic [EW-1:0] head_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r.cos_q15    <= 16'sd32767;
      dir_r.sin_q15    <= '0;
      source_height_r  <= '0;
      mirror_height_r  <= '0;
      coef_r           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcp_pkg::REG_DIR_COS:       dir_r.cos_q15   <= cfg_data[15:0];
        pcp_pkg::REG_DIR_SIN:       dir_r.sin_q15   <= cfg_data[15:0];
        pcp_pkg::REG_SOURCE_HEIGHT: source_height_r <= cfg_data[COORD_WIDTH-1:0];
        pcp_pkg::REG_MIRROR_HEIGHT: mirror_height_r <= cfg_data[COORD_WIDTH-1:0];
        pcp_pkg::REG_SPREAD:        coef_r.spread    <= cfg_data;
        pcp_pkg::REG_AMPLITUDE:     coef_r.amplitude <= cfg_data;
        pcp_pkg::REG_DECAY:         coef_r.decay     <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  pcp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_if),
    .dir           (dir_r),
    .source_height (source_height_r),
    .mirror_height (mirror_height_r),
    .fifo_full     (fifo_full),
    .push          (push),
    .entry         (push_entry)
  );

  pcp_fifo #(.WIDTH(EW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  pcp_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef_r),
    .fifo_empty (fifo_empty),
    .entry      (head_entry),
    .pop        (pop),
    .out_if     (out_if)
  );

  // the front only refuses requests when the queue is backed up
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> fifo_full)
    else $error("input stalled with room in the queue");

  // no result leaves the block right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_if.valid)
    else $error("result valid after reset");

  // nothing is taken from an empty queue
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_empty |-> !pop)
    else $error("pop from empty queue");

endmodule

@@ sim/tb_plume_concentration_point_top.sv @@
`timescale 1ns / 100ps

module tb_plume_concentration_point_top;

  localparam int       CW         = 24;
  localparam int       TAB_DEPTH  = 256;
  localparam int       LIMIT      = 600000;
  localparam int       DRAIN_WAIT = 150;
  localparam int       HOLD_LEN   = 400;
  localparam int       PHASE_LEN  = 135;
  localparam int       NUM_PHASES = 8;
  localparam logic [pcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [CW-1:0] east;
    logic signed [CW-1:0] north;
    logic signed [CW-1:0] height;
    logic signed [CW-1:0] terrain;
  } point_t;

  typedef struct {
    logic [31:0]    conc;
    pcp_pkg::zone_t zone;
  } conc_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_data;

  pcp_in_if #(.COORD_WIDTH(CW)) in_ch ();
  pcp_out_if out_ch ();

  plume_concentration_point_top #(
    .COORD_WIDTH    (CW),
    .EXP_TABLE_DEPTH(TAB_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the coefficient registers
  logic signed [15:0]   wind_cos;
  logic signed [15:0]   wind_sin;
  logic signed [CW-1:0] release_h;
  logic signed [CW-1:0] image_h;
  logic [31:0]          spread;
  logic [31:0]          amplitude;
  logic [23:0]          decay;

  logic [63:0] exp_tab [0:TAB_DEPTH];

  point_t point_queue[$];
  conc_t  conc_expected[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cnt;
  bit  hold_go;
  bit  point_taken;
  int  cycle_count;
  int  err_count;
  int  points_sent;
  int  results_seen;
  int  nonzero_seen;
  int  zone_seen [0:2];

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // min(floor(a*b / 2^sh), cap) on the full 128-bit product
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                 int sh, logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  // floor((a*ca + b*cb + half) / 2^15)
  function automatic logic signed [63:0] rotate_axis(logic signed [63:0] a,
                                                     logic signed [63:0] ca,
                                                     logic signed [63:0] b,
                                                     logic signed [63:0] cb);
    logic signed [63:0] s;
    s = a * ca + b * cb + 64'sd16384;
    return s >>> 15;
  endfunction

  function automatic logic [63:0] clamped_square(logic signed [63:0] v);
    logic [63:0] m;
    m = v < 0 ? 64'(-v) : 64'(v);
    if (m > (64'd1 << 31)) m = 64'd1 << 31;
    return m * m;
  endfunction

  // exp(-e), e in Q.16, result Q0.32
  function automatic logic [63:0] exp_neg(logic [63:0] e);
    logic [63:0] f;
    logic [63:0] n;
    logic [63:0] p;
    logic [63:0] i;
    logic [63:0] r;
    logic [63:0] v;
    f = (e * 64'd94548) >> 16;
    n = f >> 16;
    if (n > 63) return 64'd0;
    p = (f & 64'hFFFF) * TAB_DEPTH;
    i = p >> 16;
    r = p & 64'hFFFF;
    v = exp_tab[i] - (((exp_tab[i] - exp_tab[i + 1]) * r) >> 16);
    return v >> n;
  endfunction

  function automatic logic [63:0] gauss_term(logic [63:0] q, logic [63:0] recip);
    logic [63:0] m;
    logic [63:0] e;
    m = scaled_product(q, recip, 40, 64'd1 << 62);
    e = scaled_product({32'd0, spread}, m, 24, 64'd1 << 30);
    return exp_neg(e);
  endfunction

  function automatic conc_t plume_predict(point_t pt);
    conc_t              res;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ph;
    logic signed [63:0] xw;
    logic signed [63:0] yw;
    logic [63:0]        recip;
    logic [63:0]        yq;
    logic [63:0]        g_direct;
    logic [63:0]        g_image;
    logic [63:0]        darg;
    logic [63:0]        dec;
    logic [63:0]        prod;
    logic [63:0]        m;
    dx = pt.east;
    dy = pt.north;
    ph = pt.height;
    res.conc = 32'd0;
    if (pt.height < pt.terrain) begin
      res.zone = pcp_pkg::ZONE_BELOW;
      return res;
    end
    xw = rotate_axis(dx, 64'(wind_cos), dy, 64'(wind_sin));
    if (xw <= 0) begin
      res.zone = pcp_pkg::ZONE_UPWIND;
      return res;
    end
    yw = rotate_axis(dy, 64'(wind_cos), dx, -64'(wind_sin));
    recip = (64'd1 << 56) / 64'(xw);
    yq = clamped_square(yw);
    g_direct = gauss_term(yq + clamped_square(ph - 64'(release_h)), recip);
    g_image  = gauss_term(yq + clamped_square(ph - 64'(image_h)), recip);
    darg = ({40'd0, decay} * 64'(xw)) >> 16;
    if (darg > (64'd1 << 30)) darg = 64'd1 << 30;
    dec = exp_neg(darg);
    prod = scaled_product(g_direct + g_image, dec, 32, ALL_ONES);
    m = scaled_product(prod, recip, 48, ALL_ONES);
    res.conc = 32'(scaled_product({32'd0, amplitude}, m, 32, 64'hFFFF_FFFF));
    res.zone = pcp_pkg::ZONE_COMPUTED;
    return res;
  endfunction

  task automatic report(string msg);
    err_count++;
    $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // request acceptance, result checking and the run limit
  always @(posedge clk) begin
    conc_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      conc_expected.push_back(plume_predict(point_queue[0]));
      point_queue.pop_front();
      point_taken = 1'b1;
      points_sent++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (conc_expected.size() == 0) begin
        report($sformatf("unexpected result conc=%h zone=%0d",
                         out_ch.concentration, out_ch.zone));
      end else begin
        want = conc_expected.pop_front();
        if (out_ch.concentration !== want.conc)
          report($sformatf("concentration %h, want %h (zone %0d)",
                           out_ch.concentration, want.conc, want.zone));
        if (out_ch.zone !== want.zone)
          report($sformatf("zone %0d, want %0d", out_ch.zone, want.zone));
        if (want.zone <= pcp_pkg::ZONE_UPWIND) zone_seen[want.zone]++;
        if (want.conc != 0) nonzero_seen++;
      end
    end
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver, holds an offered request until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !point_taken) begin
      in_ch.valid <= 1'b1;
    end else if (point_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_ch.valid          <= 1'b1;
      in_ch.east_offset    <= point_queue[0].east;
      in_ch.north_offset   <= point_queue[0].north;
      in_ch.point_height   <= point_queue[0].height;
      in_ch.terrain_height <= point_queue[0].terrain;
    end else begin
      in_ch.valid <= 1'b0;
    end
    point_taken = 1'b0;
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_go) begin
      hold_cnt <= HOLD_LEN;
      hold_go = 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  task automatic write_reg(logic [pcp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pcp_pkg::REG_DIR_COS:       wind_cos  = val[15:0];
      pcp_pkg::REG_DIR_SIN:       wind_sin  = val[15:0];
      pcp_pkg::REG_SOURCE_HEIGHT: release_h = val[CW-1:0];
      pcp_pkg::REG_MIRROR_HEIGHT: image_h   = val[CW-1:0];
      pcp_pkg::REG_SPREAD:        spread    = val;
      pcp_pkg::REG_AMPLITUDE:     amplitude = val;
      pcp_pkg::REG_DECAY:         decay     = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] c, logic [15:0] s, logic [31:0] sh,
                           logic [31:0] mh, logic [31:0] sp, logic [31:0] am,
                           logic [31:0] dc);
    write_reg(pcp_pkg::REG_DIR_COS, {16'd0, c});
    write_reg(pcp_pkg::REG_DIR_SIN, {16'd0, s});
    write_reg(pcp_pkg::REG_SOURCE_HEIGHT, sh);
    write_reg(pcp_pkg::REG_MIRROR_HEIGHT, mh);
    write_reg(pcp_pkg::REG_SPREAD, sp);
    write_reg(pcp_pkg::REG_AMPLITUDE, am);
    write_reg(pcp_pkg::REG_DECAY, dc);
  endtask

  // wait until every request has come back, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (point_queue.size() != 0 || conc_expected.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic add_point(int e, int n, int h, int t);
    point_t pt;
    pt.east    = e[CW-1:0];
    pt.north   = n[CW-1:0];
    pt.height  = h[CW-1:0];
    pt.terrain = t[CW-1:0];
    point_queue.push_back(pt);
  endtask

  // mostly points placed downwind within the plume, plus noise
  task automatic add_random_point();
    int                 mode;
    logic signed [63:0] d;
    logic signed [63:0] c;
    logic signed [63:0] t;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      add_point(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
    end else if (mode < 15) begin
      t = $signed(16'($urandom()));
      add_point(int'($urandom_range(0, 1 << 16)), int'($signed(20'($urandom()))),
                int'(t - $urandom_range(1, 4096)), int'(t));
    end else begin
      d = $urandom_range(1, 1 << $urandom_range(2, 22));
      c = $signed(18'($urandom())) >>> $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0) d = -d;
      t = $signed(14'($urandom()));
      add_point(int'((d * wind_cos - c * wind_sin) >>> 15),
                int'((d * wind_sin + c * wind_cos) >>> 15),
                int'(t + $urandom_range(0, 1 << $urandom_range(0, 16))), int'(t));
    end
  endtask

  initial begin
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    int          idle_mode;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.east_offset = '0;
    in_ch.north_offset = '0;
    in_ch.point_height = '0;
    in_ch.terrain_height = '0;
    out_ch.ready = 1'b0;
    hold_cnt = 0;
    hold_go = 1'b0;
    cycle_count = 0;
    err_count = 0;
    points_sent = 0;
    results_seen = 0;
    nonzero_seen = 0;
    zone_seen = '{0, 0, 0};
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // exp table, 2^(-i/depth) by a truncated series of exp(-y)
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      y = (64'd2977044472 * i) / TAB_DEPTH;
      term = 64'd1 << 32;
      sum = term;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * y) >> 32) / k;
        sum = k[0] ? sum - term : sum + term;
      end
      exp_tab[i] = sum;
    end

    wind_cos = 16'sd32767;
    wind_sin = '0;
    release_h = '0;
    image_h = '0;
    spread = '0;
    amplitude = '0;
    decay = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (5) @(negedge clk);

    // reset coefficients: eastward wind, zero amplitude, every computed point gives zero
    add_point(25600, 0, 0, 0);
    add_point(256, 512, 2560, -2560);
    add_point(0, 0, 0, 0);
    add_point(-256, 0, 0, 0);
    add_point(256, 0, -1, 0);
    drain();

    // directed points with a plain eastward wind
    write_reg(REG_UNUSED, $urandom());
    write_all(16'd32767, 16'd0, 10 * 256, -10 * 256, 32'h0000_4000,
              32'h0400_0000, 32'd0);
    add_point(0, 0, 0, 0);
    add_point(-256, 5000, 0, 0);
    add_point(1, 0, 0, 0);
    add_point(8388607, 0, 0, 0);
    add_point(8388607, -8388608, 8388607, -8388608);
    add_point(-8388608, 8388607, 0, 0);
    add_point(25600, 0, -1, 0);
    add_point(25600, 0, -8388608, 8388607);
    add_point(25600, 0, -8388608, -8388608);
    add_point(25600, 0, 8388607, 8388607);
    add_point(25600, 0, 2560, 0);
    add_point(25600, 2560, 2560, 0);
    add_point(256, 2560000, 2560, 0);
    add_point(2560, 0, 2560, 2560);
    add_point(256000, 2560, 0, 0);
    add_point(256, 0, 2560, -100);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        2: write_all(16'h8000, 16'h8000, 32'h007F_FFFF, 32'hFF80_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF);
        3: write_all(16'd0, 16'd0, 32'hFF80_0000, 32'h007F_FFFF,
                     32'd0, 32'hFFFF_FFFF, 32'd0);
        5: write_all(16'd0, 16'h7FFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                     32'd0);
        default: begin
          case ($urandom_range(0, 5))
            0: write_all(16'd32767, 16'd0, 0, 0, 0, 0, 0);
            1: write_all(16'h8000, 16'd0, 0, 0, 0, 0, 0);
            2: write_all(16'd23170, 16'd23170, 0, 0, 0, 0, 0);
            3: write_all(16'hA57E, 16'd23170, 0, 0, 0, 0, 0);
            default: write_all(16'($urandom()), 16'($urandom()), 0, 0, 0, 0, 0);
          endcase
          write_reg(pcp_pkg::REG_SOURCE_HEIGHT, $signed(16'($urandom())));
          write_reg(pcp_pkg::REG_MIRROR_HEIGHT, $signed(16'($urandom())));
          write_reg(pcp_pkg::REG_SPREAD,
                    ($urandom() & 32'hFFFF) | (32'd1 << $urandom_range(4, 20)));
          write_reg(pcp_pkg::REG_AMPLITUDE, $urandom() >> $urandom_range(0, 12));
          write_reg(pcp_pkg::REG_DECAY, $urandom() >> $urandom_range(8, 31));
        end
      endcase

      // idling pattern rotates through the phases
      idle_mode = ph % 4;
      send_idle_pct  = (idle_mode == 1) ? 64 : (idle_mode == 3) ? 7 : 0;
      recv_stall_pct = (idle_mode == 2) ? 64 : (idle_mode == 3) ? 7 : 0;
      if (ph == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      for (int i = 0; i < PHASE_LEN; i++) add_random_point();
      if (ph == 4) hold_go = 1'b1;
      drain();
    end

    $display("%0d requests sent, %0d results checked (%0d nonzero)",
             points_sent, results_seen, nonzero_seen);
    $display("zones computed/below/upwind: %0d/%0d/%0d, %0d mismatches",
             zone_seen[0], zone_seen[1], zone_seen[2], err_count);
    if (err_count == 0 && conc_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
